// ----- rtl/qae_pkg.sv -----
`default_nettype none
package qae_pkg;

  // input and quaternion geometry
  localparam int PARTS = 4;
  localparam int DW    = 24;          // input part width
  localparam int NW    = DW + 1;      // part width after sign fix
  localparam int XP_W  = 2 * NW;      // one product of two parts
  localparam int SQ_W  = 49;          // squared norm, at most 2^48
  localparam int P_W   = 51;          // one part of conj(d) * a, signed
  localparam int MAG_W = 49;          // magnitude of one product part

  // wide multiplier split
  localparam int MUL_W  = 49;
  localparam int MUL_LO = 25;
  localparam int MUL_HI = MUL_W - MUL_LO;
  localparam int PROD_W = 2 * MUL_W;

  // scaling recurrence
  localparam int FRAC_BITS = 30;
  localparam int R_W       = FRAC_BITS + 1;
  localparam int STAGES    = FRAC_BITS + 1;
  localparam int E_W       = 162;     // remainder term, signed
  localparam int WA_W      = 130;     // running (2r-1)*n, signed
  localparam int OUT_W     = 32;

  // one classified item handed from front to back
  typedef struct packed {
    logic [SQ_W-1:0]                nd;
    logic [SQ_W-1:0]                na;
    logic [PARTS-1:0][MAG_W-1:0]    mag;
    logic [PARTS-1:0]               neg;
    logic                           zero;
  } qae_item_t;

endpackage
`default_nettype wire

// ----- rtl/qae_mul.sv -----
`default_nettype none
module qae_mul
  import qae_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] p
);

  logic [2*MUL_LO-1:0]      pp_ll_r;
  logic [MUL_LO+MUL_HI-1:0] pp_lh_r;
  logic [MUL_LO+MUL_HI-1:0] pp_hl_r;
  logic [2*MUL_HI-1:0]      pp_hh_r;

  // partial products
  always_ff @(posedge clk) begin
    pp_ll_r <= a[MUL_LO-1:0] * b[MUL_LO-1:0];
    pp_lh_r <= a[MUL_LO-1:0] * b[MUL_W-1:MUL_LO];
    pp_hl_r <= a[MUL_W-1:MUL_LO] * b[MUL_LO-1:0];
    pp_hh_r <= a[MUL_W-1:MUL_LO] * b[MUL_W-1:MUL_LO];
  end

  // recombine
  always_ff @(posedge clk) begin
    p <= PROD_W'(pp_ll_r)
       + (PROD_W'(pp_lh_r) << MUL_LO)
       + (PROD_W'(pp_hl_r) << MUL_LO)
       + (PROD_W'(pp_hh_r) << (2 * MUL_LO));
  end

endmodule
`default_nettype wire

// ----- rtl/qae_front.sv -----
`default_nettype none
module qae_front
  import qae_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  input  wire logic [PARTS-1:0][DW-1:0] des,
  input  wire logic [PARTS-1:0][DW-1:0] act,
  output logic                          out_vld,
  output qae_item_t                     out_item
);

  logic signed [NW-1:0]   d_nxt [PARTS];
  logic signed [NW-1:0]   a_nxt [PARTS];
  logic signed [NW-1:0]   d_r   [PARTS];
  logic signed [NW-1:0]   a_r   [PARTS];
  logic                   v0_r, v1_r, v2_r;

  logic signed [XP_W-1:0] sqd   [PARTS];
  logic signed [XP_W-1:0] sqa   [PARTS];
  logic [SQ_W-1:0]        sqd_r [PARTS];
  logic [SQ_W-1:0]        sqa_r [PARTS];
  logic signed [XP_W-1:0] c_r   [PARTS][PARTS];

  logic [SQ_W-1:0]        nd_r, na_r;
  logic signed [P_W-1:0]  p_r   [PARTS];

  // sign fix on the scalar part
  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      d_nxt[i] = $signed({des[i][DW-1], des[i]});
      a_nxt[i] = $signed({act[i][DW-1], act[i]});
      if (des[0][DW-1]) d_nxt[i] = -$signed({des[i][DW-1], des[i]});
      if (act[0][DW-1]) a_nxt[i] = -$signed({act[i][DW-1], act[i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PARTS; i++) begin
      d_r[i] <= d_nxt[i];
      a_r[i] <= a_nxt[i];
    end
  end

  // squares and cross products
  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      sqd[i] = d_r[i] * d_r[i];
      sqa[i] = a_r[i] * a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PARTS; i++) begin
      sqd_r[i] <= sqd[i][SQ_W-1:0];
      sqa_r[i] <= sqa[i][SQ_W-1:0];
      for (int j = 0; j < PARTS; j++) begin
        c_r[i][j] <= d_r[i] * a_r[j];
      end
    end
  end

  // norms and hamilton product of conj(d) and a
  always_ff @(posedge clk) begin
    nd_r <= sqd_r[0] + sqd_r[1] + sqd_r[2] + sqd_r[3];
    na_r <= sqa_r[0] + sqa_r[1] + sqa_r[2] + sqa_r[3];
    p_r[0] <= P_W'(c_r[0][0]) + P_W'(c_r[1][1]) + P_W'(c_r[2][2]) + P_W'(c_r[3][3]);
    p_r[1] <= P_W'(c_r[0][1]) - P_W'(c_r[1][0]) - P_W'(c_r[2][3]) + P_W'(c_r[3][2]);
    p_r[2] <= P_W'(c_r[0][2]) - P_W'(c_r[2][0]) - P_W'(c_r[3][1]) + P_W'(c_r[1][3]);
    p_r[3] <= P_W'(c_r[0][3]) - P_W'(c_r[3][0]) - P_W'(c_r[1][2]) + P_W'(c_r[2][1]);
  end

  // magnitudes, final signs and zero detect
  always_ff @(posedge clk) begin
    out_item.nd   <= nd_r;
    out_item.na   <= na_r;
    out_item.zero <= (nd_r == '0) || (na_r == '0);
    for (int i = 0; i < PARTS; i++) begin
      out_item.mag[i] <= p_r[i][P_W-1] ? MAG_W'(-p_r[i]) : MAG_W'(p_r[i]);
      out_item.neg[i] <= p_r[i][P_W-1] ^ p_r[0][P_W-1];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v0_r    <= in_vld;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      out_vld <= v2_r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qae_fifo.sv -----
`default_nettype none
module qae_fifo
  import qae_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire qae_item_t push_item,
  output logic           full,
  output logic           pop_vld,
  output qae_item_t      pop_item
);

  qae_item_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign pop_vld  = (cnt_r != 2'd0);
  assign pop_item = slot_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  // pointers and fill count, the back side drains every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop_vld) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop_vld);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/qae_back.sv -----
`default_nettype none
module qae_back
  import qae_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_vld,
  input  wire qae_item_t        in_item,
  output logic                  out_vld,
  output logic [R_W-1:0]        out_w,
  output logic [OUT_W-1:0]      out_x,
  output logic [OUT_W-1:0]      out_y,
  output logic [OUT_W-1:0]      out_z,
  output logic                  out_zero
);

  logic [PROD_W-1:0]       n_prod;
  logic [PROD_W-1:0]       m2    [PARTS];
  logic [1:0]              mv_r;
  logic [PARTS-1:0]        mneg_r  [2];
  logic                    mzero_r [2];

  logic signed [E_W-1:0]   e_r   [0:STAGES-1][PARTS];
  logic signed [WA_W-1:0]  w_r   [0:STAGES-1][PARTS];
  logic [R_W-1:0]          r_r   [0:STAGES][PARTS];
  logic [PROD_W-1:0]       n_r   [0:STAGES-1];
  logic [PARTS-1:0]        neg_r [0:STAGES];
  logic                    zero_r[0:STAGES];
  logic [STAGES:0]         vld_r;
  logic [OUT_W-1:0]        sgn   [PARTS];

  // n = |d|^2 |a|^2 and squared magnitudes
  qae_mul u_mul_n (.clk(clk), .a(in_item.nd), .b(in_item.na), .p(n_prod));

  for (genvar i = 0; i < PARTS; i++) begin : g_sq
    qae_mul u_mul_m (.clk(clk), .a(in_item.mag[i]), .b(in_item.mag[i]), .p(m2[i]));
  end

  // side data through the multiplier stages
  always_ff @(posedge clk) begin
    mneg_r[0]  <= in_item.neg;
    mzero_r[0] <= in_item.zero;
    mneg_r[1]  <= mneg_r[0];
    mzero_r[1] <= mzero_r[0];
  end

  // recurrence start: e = m^2 2^62 - n, w = -n, r = 0
  always_ff @(posedge clk) begin
    n_r[0]    <= n_prod;
    neg_r[0]  <= mneg_r[1];
    zero_r[0] <= mzero_r[1];
    for (int i = 0; i < PARTS; i++) begin
      e_r[0][i] <= $signed({2'b00, m2[i], {(2 * FRAC_BITS + 2){1'b0}}})
                 - $signed(E_W'(n_prod));
      w_r[0][i] <= -$signed(WA_W'(n_prod));
      r_r[0][i] <= '0;
    end
  end

  // one result bit per stage, most significant first
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int B = STAGES - 1 - s;
    for (genvar i = 0; i < PARTS; i++) begin : g_part
      logic signed [E_W-1:0] trial;
      logic                  take;
      assign trial = e_r[s][i]
                   - (E_W'(w_r[s][i]) <<< (B + 2))
                   - $signed(E_W'(n_r[s]) << (2 * B + 2));
      assign take  = !trial[E_W-1] && !r_r[s][i][R_W-1];

      always_ff @(posedge clk) begin
        r_r[s+1][i] <= take ? (r_r[s][i] | (R_W'(1) << B)) : r_r[s][i];
      end

      if (s < STAGES - 1) begin : g_rem
        always_ff @(posedge clk) begin
          e_r[s+1][i] <= take ? trial : e_r[s][i];
          w_r[s+1][i] <= take ? (w_r[s][i] + $signed(WA_W'(n_r[s]) << (B + 1)))
                              : w_r[s][i];
        end
      end
    end

    if (s < STAGES - 1) begin : g_n
      always_ff @(posedge clk) begin
        n_r[s+1] <= n_r[s];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[s+1]  <= neg_r[s];
      zero_r[s+1] <= zero_r[s];
    end
  end

  // apply signs
  always_comb begin
    for (int i = 0; i < PARTS; i++) begin
      sgn[i] = neg_r[STAGES][i] ? -OUT_W'(r_r[STAGES][i]) : OUT_W'(r_r[STAGES][i]);
      if (zero_r[STAGES]) sgn[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_w    <= zero_r[STAGES] ? '0 : r_r[STAGES][0];
    out_x    <= sgn[1];
    out_y    <= sgn[2];
    out_z    <= sgn[3];
    out_zero <= zero_r[STAGES];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r    <= '0;
      vld_r   <= '0;
      out_vld <= 1'b0;
    end else begin
      mv_r    <= {mv_r[0], in_vld};
      vld_r   <= {vld_r[STAGES-1:0], mv_r[1]};
      out_vld <= vld_r[STAGES];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/attitude_quaternion_error_top.sv -----
// quaternion attitude error, conj(desired) * actual, normalized, Q2.30 for x, y, z; w is unsigned Q1.30
// throughput: one item per cycle while busy is low; the 31-stage rounding pipeline sets the depth
// busy rises only if the front-to-back queue fills, which never happens here
// results strobe out_valid for one cycle; the receiver cannot stall
// reset: rst_n synchronous active low clears valid state; payload is not reset
`default_nettype none
module attitude_quaternion_error_top
  import qae_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DW-1:0]        in_desired_w,
  input  wire logic [DW-1:0]        in_desired_x,
  input  wire logic [DW-1:0]        in_desired_y,
  input  wire logic [DW-1:0]        in_desired_z,
  input  wire logic [DW-1:0]        in_actual_w,
  input  wire logic [DW-1:0]        in_actual_x,
  input  wire logic [DW-1:0]        in_actual_y,
  input  wire logic [DW-1:0]        in_actual_z,
  output logic                      out_valid,
  output logic [R_W-1:0]            out_error_w,
  output logic [OUT_W-1:0]          out_error_x,
  output logic [OUT_W-1:0]          out_error_y,
  output logic [OUT_W-1:0]          out_error_z,
  output logic                      out_zero_norm
);

  logic                     accept;
  logic                     f_vld, q_vld;
  qae_item_t                f_item, q_item;
  logic [PARTS-1:0][DW-1:0] des, act;

  assign accept = start && !busy;
  assign des = {in_desired_z, in_desired_y, in_desired_x, in_desired_w};
  assign act = {in_actual_z, in_actual_y, in_actual_x, in_actual_w};

  // front: sign fix, products, norms
  qae_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .des(des), .act(act),
    .out_vld(f_vld), .out_item(f_item)
  );

  // queue between front and back
  qae_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_vld), .push_item(f_item),
    .full(busy), .pop_vld(q_vld), .pop_item(q_item)
  );

  // back: normalization and rounding
  qae_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_vld), .in_item(q_item),
    .out_vld(out_valid), .out_w(out_error_w), .out_x(out_error_x),
    .out_y(out_error_y), .out_z(out_error_z), .out_zero(out_zero_norm)
  );

endmodule
`default_nettype wire

// ----- sim/qae_checker.sv -----
`default_nettype none
module qae_checker
  import qae_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [DW-1:0]    in_desired_w,
  input  wire logic [DW-1:0]    in_desired_x,
  input  wire logic [DW-1:0]    in_desired_y,
  input  wire logic [DW-1:0]    in_desired_z,
  input  wire logic [DW-1:0]    in_actual_w,
  input  wire logic [DW-1:0]    in_actual_x,
  input  wire logic [DW-1:0]    in_actual_y,
  input  wire logic [DW-1:0]    in_actual_z,
  input  wire logic             out_valid,
  input  wire logic [R_W-1:0]   out_error_w,
  input  wire logic [OUT_W-1:0] out_error_x,
  input  wire logic [OUT_W-1:0] out_error_y,
  input  wire logic [OUT_W-1:0] out_error_z,
  input  wire logic             out_zero_norm,
  output int                    fail_count,
  output int                    pending,
  output int                    checked_count,
  output int                    zero_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [R_W-1:0]   w;
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             zn;
  } qerr_t;

  qerr_t error_queue[$];

  initial begin
    fail_count    = 0;
    checked_count = 0;
    zero_count    = 0;
  end

  assign pending = error_queue.size();

  // round(m * 2^30 / sqrt(n)), ties away from zero, by bitwise search
  function automatic logic [R_W-1:0] unit_scale(logic [63:0] m, logic [191:0] n);
    logic [191:0] rhs;
    logic [191:0] odd;
    logic [191:0] lhs;
    logic [63:0]  r;
    logic [63:0]  t;
    r   = 0;
    rhs = ({128'd0, m} * {128'd0, m}) << (2 * FRAC_BITS + 2);
    for (int b = FRAC_BITS; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= (64'd1 << FRAC_BITS)) begin
        odd = {128'd0, 2 * t - 1};
        lhs = odd * odd * n;
        if (lhs <= rhs) r = t;
      end
    end
    return r[R_W-1:0];
  endfunction

  // error quaternion of conj(desired) * actual, normalized
  function automatic qerr_t attitude_error(logic [7:0][DW-1:0] raw);
    longint       d[4];
    longint       a[4];
    longint       p[4];
    longint       nd;
    longint       na;
    logic [191:0] n;
    logic [R_W-1:0] r;
    logic [OUT_W-1:0] s[4];
    qerr_t        e;
    nd = 0;
    na = 0;
    for (int i = 0; i < 4; i++) begin
      d[i] = longint'($signed(raw[7 - i]));
      a[i] = longint'($signed(raw[3 - i]));
    end
    if (d[0] < 0) for (int i = 0; i < 4; i++) d[i] = -d[i];
    if (a[0] < 0) for (int i = 0; i < 4; i++) a[i] = -a[i];
    for (int i = 0; i < 4; i++) begin
      nd += d[i] * d[i];
      na += a[i] * a[i];
    end
    if (nd == 0 || na == 0) begin
      e = '{w: '0, x: '0, y: '0, z: '0, zn: 1'b1};
      return e;
    end
    p[0] = d[0] * a[0] + d[1] * a[1] + d[2] * a[2] + d[3] * a[3];
    p[1] = d[0] * a[1] - a[0] * d[1] - d[2] * a[3] + d[3] * a[2];
    p[2] = d[0] * a[2] - a[0] * d[2] - d[3] * a[1] + d[1] * a[3];
    p[3] = d[0] * a[3] - a[0] * d[3] - d[1] * a[2] + d[2] * a[1];
    if (p[0] < 0) for (int i = 0; i < 4; i++) p[i] = -p[i];
    n = {128'd0, 64'(nd)} * {128'd0, 64'(na)};
    for (int i = 0; i < 4; i++) begin
      r = unit_scale(64'(p[i] < 0 ? -p[i] : p[i]), n);
      s[i] = p[i] < 0 ? -{1'b0, r} : {1'b0, r};
    end
    e = '{w: s[0][R_W-1:0], x: s[1], y: s[2], z: s[3], zn: 1'b0};
    return e;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // compare results first, then record the item taken at this edge
  always @(posedge clk) begin
    qerr_t e;
    if (rst_n && out_valid) begin
      if (error_queue.size() == 0) begin
        report("unexpected result", 64'(out_error_w), 64'd0);
      end else begin
        e = error_queue.pop_front();
        checked_count++;
        if (e.zn) zero_count++;
        if (out_error_w !== e.w) report("error_w", 64'(out_error_w), 64'(e.w));
        if (out_error_x !== e.x) report("error_x", 64'(out_error_x), 64'(e.x));
        if (out_error_y !== e.y) report("error_y", 64'(out_error_y), 64'(e.y));
        if (out_error_z !== e.z) report("error_z", 64'(out_error_z), 64'(e.z));
        if (out_zero_norm !== e.zn) report("zero_norm", 64'(out_zero_norm), 64'(e.zn));
      end
    end
    if (rst_n && start && !busy)
      error_queue.push_back(attitude_error({in_desired_w, in_desired_x, in_desired_y,
                                            in_desired_z, in_actual_w, in_actual_x,
                                            in_actual_y, in_actual_z}));
  end

endmodule
`default_nettype wire

// ----- sim/tb_attitude_quaternion_error_top.sv -----
`default_nettype none
module tb_attitude_quaternion_error_top
  import qae_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 40;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1750;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [DW-1:0] q[8];
  logic out_valid;
  logic [R_W-1:0] out_error_w;
  logic [OUT_W-1:0] out_error_x, out_error_y, out_error_z;
  logic out_zero_norm;
  int fail_count, pending, checked_count, zero_count;
  int idle_cycles;
  int sent;

  attitude_quaternion_error_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_desired_w(q[0]), .in_desired_x(q[1]), .in_desired_y(q[2]), .in_desired_z(q[3]),
    .in_actual_w(q[4]), .in_actual_x(q[5]), .in_actual_y(q[6]), .in_actual_z(q[7]),
    .out_valid(out_valid), .out_error_w(out_error_w), .out_error_x(out_error_x),
    .out_error_y(out_error_y), .out_error_z(out_error_z), .out_zero_norm(out_zero_norm)
  );

  qae_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_desired_w(q[0]), .in_desired_x(q[1]), .in_desired_y(q[2]), .in_desired_z(q[3]),
    .in_actual_w(q[4]), .in_actual_x(q[5]), .in_actual_y(q[6]), .in_actual_z(q[7]),
    .out_valid(out_valid), .out_error_w(out_error_w), .out_error_x(out_error_x),
    .out_error_y(out_error_y), .out_error_z(out_error_z), .out_zero_norm(out_zero_norm),
    .fail_count(fail_count), .pending(pending), .checked_count(checked_count),
    .zero_count(zero_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one item and hold it until taken
  task automatic send_item(logic [DW-1:0] v[8]);
    @(negedge clk);
    start <= 1'b1;
    for (int i = 0; i < 8; i++) q[i] <= v[i];
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [DW-1:0] rand_part(int style);
    case (style)
      0: return DW'($urandom);
      1: return DW'($signed($urandom_range(0, 32)) - 16);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return DW'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // directed corners then mixed random quaternion pairs
  initial begin
    logic [DW-1:0] v[8];
    logic [DW-1:0] dir[$][8];
    int burst, style;
    idle_cycles = 0;
    sent  = 0;
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 8; i++) q[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir.push_back('{24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                    24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff});
    dir.push_back('{24'h800000, 24'h800000, 24'h800000, 24'h800000,
                    24'h800000, 24'h800000, 24'h800000, 24'h800000});
    dir.push_back('{24'h800000, 0, 0, 0, 24'h7fffff, 0, 0, 0});
    dir.push_back('{0, 0, 0, 0, 1, 2, 3, 4});
    dir.push_back('{5, 6, 7, 8, 0, 0, 0, 0});
    dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
    dir.push_back('{1, 0, 0, 0, 1, 0, 0, 0});
    dir.push_back('{1, 0, 0, 0, 0, 1, 0, 0});
    dir.push_back('{1, 0, 0, 0, 0, 0, 1, 0});
    dir.push_back('{1, 0, 0, 0, 0, 0, 0, 24'hffffff});
    dir.push_back('{24'hffffff, 0, 0, 0, 1, 0, 0, 0});
    dir.push_back('{24'hfffffd, 1, 2, 3, 3, 24'hffffff, 24'hfffffe, 24'hfffffd});
    dir.push_back('{1, 1, 1, 1, 1, 1, 1, 1});
    dir.push_back('{1, 1, 1, 1, 24'hffffff, 1, 1, 1});
    dir.push_back('{0, 1, 0, 0, 0, 0, 1, 0});
    dir.push_back('{0, 0, 0, 24'h800000, 0, 24'h7fffff, 0, 0});
    dir.push_back('{24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
                    24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff});
    dir.push_back('{3, 4, 0, 0, 4, 3, 0, 0});
    dir.push_back('{1, 0, 0, 0, 1, 1, 0, 0});
    dir.push_back('{1, 0, 0, 0, 24'h7fffff, 1, 0, 0});
    foreach (dir[k]) send_item(dir[k]);

    while (sent < RANDOM_ITEMS + 20) begin
      burst = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        style = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++) v[i] = rand_part(style < 5 ? 0 : style - 5);
        // zero quaternions and matching pairs now and then
        case ($urandom_range(0, 19))
          0: for (int i = 0; i < 4; i++) v[i] = '0;
          1: for (int i = 4; i < 8; i++) v[i] = '0;
          2: for (int i = 4; i < 8; i++) v[i] = v[i - 4];
          3: for (int i = 4; i < 8; i++) v[i] = -v[i - 4];
          default: ;
        endcase
        send_item(v);
      end
      if (sent > 900 && sent < 900 + burst + 1) begin
        pause(1);
        wait (pending == 0);
      end else if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 2 * LATENCY));
      end
    end

    pause(1);
    wait (pending == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("%0d quaternion pairs sent, %0d results checked, %0d flagged zero norm",
             sent, checked_count, zero_count);
    $display("corners, sign flips, zero inputs and random pairs under bursty traffic");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/qae_pkg.sv
rtl/qae_mul.sv
rtl/qae_front.sv
rtl/qae_fifo.sv
rtl/qae_back.sv
rtl/attitude_quaternion_error_top.sv
sim/qae_checker.sv
sim/tb_attitude_quaternion_error_top.sv
